### design/eturx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eturx_pkg
// Shared types, codes and ring helpers of the edge timing serial receiver.
// ----------------------------------------------------------------------------
package eturx_pkg;

    localparam int RING_DEPTH = 256;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] RING_LAST = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_RESET = IDX_W'(1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIME       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGEST_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_SHIFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_SHIFT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LINE    = 3'd4;

    localparam logic [7:0]  BIT_TIME_RESET   = 8'd13;
    localparam logic [10:0] LONGEST_RESET    = 11'd58;
    localparam logic [1:0]  DOWN_SHIFT_RESET = 2'd0;
    localparam logic [1:0]  UP_SHIFT_RESET   = 2'd1;
    localparam logic        INVERT_RESET     = 1'b1;

    localparam logic [7:0] DUR_SATURATED = 8'd255;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        OP_EDGE     = 2'd0,
        OP_GET      = 2'd1,
        OP_STOP     = 2'd2,
        OP_RESERVED = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_BYTE       = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_BREAK      = 3'd3,
        ST_FRAMING    = 3'd4,
        ST_STORED     = 3'd5,
        ST_OVERFLOW   = 3'd6,
        ST_SYNC_DROP  = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD_IN,
        CMD_EDGE,
        CMD_STOP,
        CMD_BAD_OP,
        CMD_GET_START,
        CMD_LOAD_LD,
        CMD_BIT_STEP,
        CMD_LOAD_SHIFT,
        CMD_TAIL,
        CMD_POST,
        CMD_PUBLISH
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WAIT_FIRST,
        S_LOAD_FIRST,
        S_BIT,
        S_WAIT_NEXT,
        S_LOAD_NEXT,
        S_TAIL,
        S_POST,
        S_FINISH
    } state_t;

    typedef struct packed {
        op_t  op;
        logic get_early;
        logic step_over;
        logic step_head;
        logic bits_last;
        logic tail_fail;
        logic out_free;
    } dp_status_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == RING_LAST) ? '0 : idx + IDX_W'(1);
    endfunction

endpackage

### design/edge_timing_uart_receiver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_timing_uart_receiver_unit
// 8N1 serial receiver that rebuilds bytes from timed line edges.
//
// Input channel (in_valid / in_stall): one word per operation. An edge word
// stores the scaled duration of the period just ended, a stop word closes the
// ring on a high period, a get word rebuilds one byte from stored periods.
// Output channel (out_valid / out_stall): one result word per input word,
// status plus rx_byte. Configuration is written through cfg_write; the user
// must do so only while idle, as the block itself does not enforce it.
// Edge, stop and reserved words pass a dispatch and a finish state before the
// result is registered in the output register; the next word can be taken
// as soon as that result shows. A get on an empty ring or on a single stored
// period takes the same path; otherwise it walks the ring, one registered read
// per period, through the bits, then a tail state and, if that passes, a post.
// One word is worked on at a time; a new word is taken once the result sits
// in the output register, even while out_stall holds it there.
// Reset sets both ring indexes to one (a stop bit is presumed) and loads
// the configuration defaults; the ring itself is not cleared. While out_stall
// is high a finished result waits and the next word stalls at its end.
// ----------------------------------------------------------------------------
module edge_timing_uart_receiver_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        operation,
    input  logic                              pin_level,
    input  logic [15:0]                       elapsed_ticks,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [7:0]                        rx_byte,
    input  logic                              cfg_write,
    input  logic [eturx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eturx_pkg::CFG_DATA_W-1:0]  cfg_data
);

    eturx_pkg::cmd_t       cmd;
    eturx_pkg::dp_status_t dp_status;

    eturx_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    eturx_dpath u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .dp_status     (dp_status),
        .operation     (operation),
        .pin_level     (pin_level),
        .elapsed_ticks (elapsed_ticks),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .rx_byte       (rx_byte)
    );

endmodule

### design/eturx_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eturx_ctrl
// Sequencer: accepts a word, steps the datapath through an edge store, a stop,
// a reserved word or a byte rebuild, then hands the result to the output register.
// ----------------------------------------------------------------------------
module eturx_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  eturx_pkg::dp_status_t  dp_status,
    output eturx_pkg::cmd_t        cmd
);

    eturx_pkg::state_t state_reg;
    eturx_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= eturx_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = eturx_pkg::CMD_NONE;
        in_stall   = 1'b1;
        case (state_reg)
            eturx_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd        = eturx_pkg::CMD_LOAD_IN;
                    state_next = eturx_pkg::S_DISPATCH;
                end
            end
            eturx_pkg::S_DISPATCH:
            begin
                state_next = eturx_pkg::S_FINISH;
                case (dp_status.op)
                    eturx_pkg::OP_EDGE: cmd = eturx_pkg::CMD_EDGE;
                    eturx_pkg::OP_STOP: cmd = eturx_pkg::CMD_STOP;
                    eturx_pkg::OP_GET:
                    begin
                        cmd = eturx_pkg::CMD_GET_START;
                        if (!dp_status.get_early)
                        begin
                            state_next = eturx_pkg::S_WAIT_FIRST;
                        end
                    end
                    default: cmd = eturx_pkg::CMD_BAD_OP;
                endcase
            end
            eturx_pkg::S_WAIT_FIRST:
            begin
                state_next = eturx_pkg::S_LOAD_FIRST;
            end
            eturx_pkg::S_LOAD_FIRST:
            begin
                cmd        = eturx_pkg::CMD_LOAD_LD;
                state_next = eturx_pkg::S_BIT;
            end
            eturx_pkg::S_BIT:
            begin
                cmd = eturx_pkg::CMD_BIT_STEP;
                if (dp_status.step_over)
                begin
                    state_next = dp_status.step_head ? eturx_pkg::S_TAIL
                                                     : eturx_pkg::S_WAIT_NEXT;
                end
                else
                begin
                    state_next = dp_status.bits_last ? eturx_pkg::S_TAIL
                                                     : eturx_pkg::S_BIT;
                end
            end
            eturx_pkg::S_WAIT_NEXT:
            begin
                state_next = eturx_pkg::S_LOAD_NEXT;
            end
            eturx_pkg::S_LOAD_NEXT:
            begin
                cmd        = eturx_pkg::CMD_LOAD_SHIFT;
                state_next = dp_status.bits_last ? eturx_pkg::S_TAIL : eturx_pkg::S_BIT;
            end
            eturx_pkg::S_TAIL:
            begin
                cmd        = eturx_pkg::CMD_TAIL;
                state_next = dp_status.tail_fail ? eturx_pkg::S_FINISH : eturx_pkg::S_POST;
            end
            eturx_pkg::S_POST:
            begin
                cmd        = eturx_pkg::CMD_POST;
                state_next = eturx_pkg::S_FINISH;
            end
            eturx_pkg::S_FINISH:
            begin
                if (dp_status.out_free)
                begin
                    cmd        = eturx_pkg::CMD_PUBLISH;
                    state_next = eturx_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = eturx_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### design/eturx_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eturx_dpath
// Datapath: configuration, duration ring, ring indexes, bit walk registers
// and the output register.
// ----------------------------------------------------------------------------
module eturx_dpath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  eturx_pkg::cmd_t                   cmd,
    output eturx_pkg::dp_status_t             dp_status,
    input  logic [1:0]                        operation,
    input  logic                              pin_level,
    input  logic [15:0]                       elapsed_ticks,
    input  logic                              cfg_write,
    input  logic [eturx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [eturx_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        status,
    output logic [7:0]                        rx_byte
);

    localparam int IW = eturx_pkg::IDX_W;

    // configuration
    logic [7:0]  bit_time_reg;
    logic [10:0] longest_reg;
    logic [1:0]  down_shift_reg;
    logic [1:0]  up_shift_reg;
    logic        invert_reg;

    // control state
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          out_valid_reg, out_valid_next;

    // payload
    eturx_pkg::op_t     op_reg, op_next;
    logic               level_reg, level_next;
    logic [15:0]        ticks_reg, ticks_next;
    logic [IW-1:0]      curr_reg, curr_next;
    logic [7:0]         cbt_reg, cbt_next;
    logic [3:0]         bits_reg, bits_next;
    logic [7:0]         data_reg, data_next;
    logic [7:0]         ld_reg, ld_next;
    eturx_pkg::status_t res_status_reg, res_status_next;
    logic [7:0]         res_byte_reg, res_byte_next;
    eturx_pkg::status_t out_status_reg, out_status_next;
    logic [7:0]         out_byte_reg, out_byte_next;

    logic [7:0] ring_mem [eturx_pkg::RING_DEPTH];
    logic [7:0] rd_data_reg;
    logic       ring_we;

    logic [7:0]    dur_shifted;
    logic [7:0]    scaled;
    logic [7:0]    half;
    logic [7:0]    ld_raw;
    logic [7:0]    load_val;
    logic [7:0]    cbt_sum;
    logic [IW-1:0] wr_idx_inc;
    logic [IW-1:0] rd_idx_inc;
    logic [IW-1:0] curr_inc;
    logic [11:0]   tail_thr;
    logic [7:0]    data_fill;
    logic          tail_fail;
    logic [IW-1:0] post_idx;

    // tick scaling
    always_comb
    begin
        dur_shifted = 8'(ticks_reg >> down_shift_reg);
        if (ticks_reg > {5'd0, longest_reg})
        begin
            scaled = eturx_pkg::DUR_SATURATED;
        end
        else
        begin
            scaled = dur_shifted << up_shift_reg;
        end
    end

    assign half       = bit_time_reg >> 1;
    assign ld_raw     = (rd_data_reg < half) ? bit_time_reg : rd_data_reg;
    assign load_val   = ld_raw - half;
    assign cbt_sum    = cbt_reg + bit_time_reg;
    assign wr_idx_inc = eturx_pkg::ring_next(wr_idx_reg);
    assign rd_idx_inc = eturx_pkg::ring_next(rd_idx_reg);
    assign curr_inc   = eturx_pkg::ring_next(curr_reg);
    assign tail_thr   = 12'(bits_reg) * 12'(bit_time_reg) + 12'(half);
    assign data_fill  = (data_reg >> bits_reg) | ~(8'hFF >> bits_reg);
    assign tail_fail  = (bits_reg != 4'd0)
                        && (!curr_reg[0] || ({4'd0, scaled} < tail_thr));
    assign post_idx   = (cbt_sum > ld_reg) ? curr_inc : curr_reg;

    assign dp_status.op        = op_reg;
    assign dp_status.get_early = (rd_idx_reg == wr_idx_reg) || (rd_idx_inc == wr_idx_reg);
    assign dp_status.step_over = cbt_sum > ld_reg;
    assign dp_status.step_head = curr_inc == wr_idx_reg;
    assign dp_status.bits_last = bits_reg == 4'd1;
    assign dp_status.tail_fail = tail_fail;
    assign dp_status.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        wr_idx_next     = wr_idx_reg;
        rd_idx_next     = rd_idx_reg;
        op_next         = op_reg;
        level_next      = level_reg;
        ticks_next      = ticks_reg;
        curr_next       = curr_reg;
        cbt_next        = cbt_reg;
        bits_next       = bits_reg;
        data_next       = data_reg;
        ld_next         = ld_reg;
        res_status_next = res_status_reg;
        res_byte_next   = res_byte_reg;
        out_status_next = out_status_reg;
        out_byte_next   = out_byte_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ring_we         = 1'b0;
        case (cmd)
            eturx_pkg::CMD_LOAD_IN:
            begin
                op_next    = eturx_pkg::op_t'(operation);
                level_next = pin_level;
                ticks_next = elapsed_ticks;
            end
            eturx_pkg::CMD_EDGE:
            begin
                res_byte_next = 8'd0;
                if (wr_idx_inc == rd_idx_reg)
                begin
                    res_status_next = eturx_pkg::ST_OVERFLOW;
                end
                else if (wr_idx_reg[0] == (level_reg ^ invert_reg))
                begin
                    res_status_next = eturx_pkg::ST_SYNC_DROP;
                end
                else
                begin
                    ring_we         = 1'b1;
                    wr_idx_next     = wr_idx_inc;
                    res_status_next = eturx_pkg::ST_STORED;
                end
            end
            eturx_pkg::CMD_STOP:
            begin
                wr_idx_next     = wr_idx_reg | IW'(1);
                res_status_next = eturx_pkg::ST_STORED;
                res_byte_next   = 8'd0;
            end
            eturx_pkg::CMD_BAD_OP:
            begin
                res_status_next = eturx_pkg::ST_SYNC_DROP;
                res_byte_next   = 8'd0;
            end
            eturx_pkg::CMD_GET_START:
            begin
                res_byte_next = 8'd0;
                if (rd_idx_reg == wr_idx_reg)
                begin
                    res_status_next = eturx_pkg::ST_EMPTY;
                end
                else if (rd_idx_inc == wr_idx_reg)
                begin
                    res_status_next = eturx_pkg::ST_INCOMPLETE;
                end
                curr_next = rd_idx_inc;
                cbt_next  = 8'd0;
                bits_next = eturx_pkg::BITS_PER_BYTE;
                data_next = 8'd0;
            end
            eturx_pkg::CMD_LOAD_LD:
            begin
                ld_next = load_val;
            end
            eturx_pkg::CMD_BIT_STEP:
            begin
                if (cbt_sum > ld_reg)
                begin
                    // period used up, move on to the next stored period
                    cbt_next  = 8'd0;
                    curr_next = curr_inc;
                end
                else
                begin
                    cbt_next  = cbt_sum;
                    data_next = {curr_reg[0], data_reg[7:1]};
                    bits_next = bits_reg - 4'd1;
                end
            end
            eturx_pkg::CMD_LOAD_SHIFT:
            begin
                ld_next   = load_val;
                data_next = {curr_reg[0], data_reg[7:1]};
                bits_next = bits_reg - 4'd1;
            end
            eturx_pkg::CMD_TAIL:
            begin
                if (tail_fail)
                begin
                    res_status_next = eturx_pkg::ST_INCOMPLETE;
                    res_byte_next   = 8'd0;
                end
                else if (bits_reg != 4'd0)
                begin
                    // remaining bits come from the high period in progress
                    data_next = data_fill;
                    ld_next   = scaled;
                end
            end
            eturx_pkg::CMD_POST:
            begin
                if (post_idx[0])
                begin
                    rd_idx_next     = post_idx;
                    res_status_next = eturx_pkg::ST_BYTE;
                    res_byte_next   = data_reg;
                end
                else
                begin
                    rd_idx_next     = eturx_pkg::ring_next(post_idx);
                    res_status_next = (data_reg == 8'd0) ? eturx_pkg::ST_BREAK
                                                         : eturx_pkg::ST_FRAMING;
                    res_byte_next   = 8'd0;
                end
            end
            eturx_pkg::CMD_PUBLISH:
            begin
                out_status_next = res_status_reg;
                out_byte_next   = res_byte_reg;
                out_valid_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_time_reg   <= eturx_pkg::BIT_TIME_RESET;
            longest_reg    <= eturx_pkg::LONGEST_RESET;
            down_shift_reg <= eturx_pkg::DOWN_SHIFT_RESET;
            up_shift_reg   <= eturx_pkg::UP_SHIFT_RESET;
            invert_reg     <= eturx_pkg::INVERT_RESET;
            wr_idx_reg     <= eturx_pkg::IDX_RESET;
            rd_idx_reg     <= eturx_pkg::IDX_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    eturx_pkg::CFG_BIT_TIME:       bit_time_reg   <= cfg_data[7:0];
                    eturx_pkg::CFG_LONGEST_PERIOD: longest_reg    <= cfg_data;
                    eturx_pkg::CFG_DOWN_SHIFT:     down_shift_reg <= cfg_data[1:0];
                    eturx_pkg::CFG_UP_SHIFT:       up_shift_reg   <= cfg_data[1:0];
                    eturx_pkg::CFG_INVERT_LINE:    invert_reg     <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        level_reg      <= level_next;
        ticks_reg      <= ticks_next;
        curr_reg       <= curr_next;
        cbt_reg        <= cbt_next;
        bits_reg       <= bits_next;
        data_reg       <= data_next;
        ld_reg         <= ld_next;
        res_status_reg <= res_status_next;
        res_byte_reg   <= res_byte_next;
        out_status_reg <= out_status_next;
        out_byte_reg   <= out_byte_next;
    end

    // duration ring, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wr_idx_reg] <= scaled;
        end
        rd_data_reg <= ring_mem[curr_reg];
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign rx_byte   = out_byte_reg;

endmodule

### design/eturx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eturx_checker
// Port level checks of the receiver, bound to the top level.
// ----------------------------------------------------------------------------
module eturx_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] status,
    input logic [7:0] rx_byte
);

    // held result word keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(rx_byte))
        else $error("stalled result word changed");

    // rx_byte is zero unless a byte is reported
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != 3'(eturx_pkg::ST_BYTE)) |-> rx_byte == 8'd0)
        else $error("rx_byte not zero on a non byte status");

    // an accepted word keeps the block busy through the dispatch state and the state after it
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input taken again too early");

    // a new result word follows a busy cycle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without work");

endmodule

bind edge_timing_uart_receiver_unit eturx_checker u_eturx_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .rx_byte   (rx_byte)
);
